// ===== sv/ialu_pkg.sv =====
// Package with the opcodes, controller states and control structs of the 128-bit ALU.
`default_nettype none
package ialu_pkg;

  typedef enum logic [3:0] {
    FN_ADD = 4'd0,
    FN_SUB = 4'd1,
    FN_MUL = 4'd2,
    FN_DIV = 4'd3,
    FN_MOD = 4'd4,
    FN_AND = 4'd5,
    FN_OR  = 4'd6,
    FN_XOR = 4'd7,
    FN_SHL = 4'd8,
    FN_SHR = 4'd9,
    FN_CMP = 4'd10,
    FN_NEG = 4'd11
  } func_e;

  localparam logic [1:0] MODE_UU = 2'd0;
  localparam logic [1:0] MODE_SS = 2'd1;
  localparam logic [1:0] MODE_SU = 2'd2;

  localparam int unsigned FieldBits = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_RUN,
    ST_FIX,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic step;
    logic fix;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic long_op;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/ialu_ctrl.sv =====
// Controller state machine: sequences operand load, setup, iterations and result transfer.
`default_nettype none
module ialu_ctrl #(
  parameter int unsigned WORD_BITS = 128
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  input  wire ialu_pkg::status_t status_i,
  output ialu_pkg::cmd_t        cmd_o
);

  localparam int unsigned CntBits = $clog2(WORD_BITS);

  ialu_pkg::state_e state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ialu_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ialu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ialu_pkg::ST_PREP;
        end
      end
      ialu_pkg::ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = CntBits'(WORD_BITS - 1);
        state_d    = status_i.long_op ? ialu_pkg::ST_RUN : ialu_pkg::ST_DONE;
      end
      ialu_pkg::ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ialu_pkg::ST_FIX;
        end
      end
      ialu_pkg::ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ialu_pkg::ST_DONE;
      end
      ialu_pkg::ST_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ialu_pkg::ST_IDLE;
        end
      end
      default: state_d = ialu_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== sv/ialu_dp.sv =====
// Datapath: operand registers, the simple operations done at setup, shift-add multiply and restoring divide.
`default_nettype none
module ialu_dp #(
  parameter int unsigned WORD_BITS = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ialu_pkg::cmd_t        cmd_i,
  output ialu_pkg::status_t          status_o,
  input  wire logic [3:0]            func_i,
  input  wire logic [1:0]            mode_i,
  input  wire logic [WORD_BITS-1:0]  a_i,
  input  wire logic [WORD_BITS-1:0]  b_i,
  output logic [2*ialu_pkg::FieldBits-1:0] r_o,
  output logic                       less_o,
  output logic                       equal_o,
  output logic                       greater_o,
  output logic                       div_zero_o
);

  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned ShBits = $clog2(WORD_BITS);
  localparam logic [W-1:0] WLimit = W'(WORD_BITS);

  logic [3:0]   func_q;
  logic [1:0]   mode_q;
  logic [W-1:0] a_q, a_d, b_q, b_d, acc_q, acc_d, res_q, res_d;
  logic         sa_q, sa_d, sb_q, sb_d;
  logic [3:0]   flags_q, flags_d;
  logic [2*ialu_pkg::FieldBits-1:0] out_q;
  logic [3:0]   oflags_q;

  logic [W-1:0] neg_a, neg_b, cnt, shl_r, shr_r, fix_src;
  logic [2*W-1:0] shr_ext;
  logic [ShBits-1:0] amt;
  logic sa, sb, a_signed, left, big, b_zero, fill;
  logic [W-1:0] rem_sh;
  logic [W:0]   trial;
  logic         out_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oflags_q <= '0;
    end else if (cmd_i.load_out) begin
      oflags_q <= flags_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      mode_q <= mode_i;
    end
    if (cmd_i.load_out) begin
      out_q <= (2*ialu_pkg::FieldBits)'(res_q);
    end
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    sa_q    <= sa_d;
    sb_q    <= sb_d;
    flags_q <= flags_d;
  end

  always_comb begin
    a_signed = (mode_q == ialu_pkg::MODE_SS) || (mode_q == ialu_pkg::MODE_SU);
    sa       = a_signed & a_q[W-1];
    sb       = (mode_q == ialu_pkg::MODE_SS) & b_q[W-1];
    neg_a    = '0 - a_q;
    neg_b    = '0 - b_q;
    b_zero   = (b_q == '0);
    cnt      = sb ? neg_b : b_q;
    big      = (cnt >= WLimit);
    amt      = cnt[ShBits-1:0];
    left     = (func_q == ialu_pkg::FN_SHL) ^ sb;
    fill     = a_signed & a_q[W-1];
    shl_r    = a_q << amt;
    shr_ext  = {{W{fill}}, a_q} >> amt;
    shr_r    = shr_ext[W-1:0];
    status_o.long_op = (func_q == ialu_pkg::FN_MUL) ||
                       (((func_q == ialu_pkg::FN_DIV) || (func_q == ialu_pkg::FN_MOD)) &&
                        !b_zero);

    // One restoring-division step: remainder in acc_q, dividend shifts out of a_q.
    out_bit = acc_q[W-1];
    rem_sh  = {acc_q[W-2:0], a_q[W-1]};
    trial   = {out_bit, rem_sh} - {1'b0, b_q};

    unique case (func_q)
      ialu_pkg::FN_DIV: fix_src = (sa_q ^ sb_q) ? ('0 - a_q) : a_q;
      ialu_pkg::FN_MOD: fix_src = sa_q ? ('0 - acc_q) : acc_q;
      default:          fix_src = acc_q;
    endcase

    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    res_d   = res_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    flags_d = flags_q;

    if (cmd_i.load_in) begin
      a_d = a_i;
      b_d = b_i;
    end else if (cmd_i.prep) begin
      res_d   = '0;
      flags_d = '0;
      acc_d   = '0;
      sa_d    = sa;
      sb_d    = sb;
      case (func_q) inside
        ialu_pkg::FN_ADD: res_d = a_q + b_q;
        ialu_pkg::FN_SUB: res_d = a_q - b_q;
        ialu_pkg::FN_AND: res_d = a_q & b_q;
        ialu_pkg::FN_OR:  res_d = a_q | b_q;
        ialu_pkg::FN_XOR: res_d = a_q ^ b_q;
        ialu_pkg::FN_NEG: res_d = neg_a;
        ialu_pkg::FN_SHL, ialu_pkg::FN_SHR: begin
          if (!big) begin
            res_d = left ? shl_r : shr_r;
          end
        end
        ialu_pkg::FN_CMP: begin
          // flags order: less, equal, greater, div_zero
          if (sa != sb) begin
            flags_d = {sa, 1'b0, sb, 1'b0};
          end else if (a_q == b_q) begin
            flags_d = 4'b0100;
          end else if (a_q < b_q) begin
            flags_d = 4'b1000;
          end else begin
            flags_d = 4'b0010;
          end
        end
        ialu_pkg::FN_DIV, ialu_pkg::FN_MOD: begin
          if (b_zero) begin
            flags_d = 4'b0001;
          end else begin
            a_d = sa ? neg_a : a_q;
            b_d = sb ? neg_b : b_q;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step) begin
      if (func_q == ialu_pkg::FN_MUL) begin
        if (b_q[0]) begin
          acc_d = acc_q + a_q;
        end
        a_d = a_q << 1;
        b_d = b_q >> 1;
      end else begin
        if (!trial[W]) begin
          acc_d = trial[W-1:0];
        end else begin
          acc_d = rem_sh;
        end
        a_d = {a_q[W-2:0], ~trial[W]};
      end
    end else if (cmd_i.fix) begin
      res_d = fix_src;
    end
  end

  assign r_o        = out_q;
  assign less_o     = oflags_q[3];
  assign equal_o    = oflags_q[2];
  assign greater_o  = oflags_q[1];
  assign div_zero_o = oflags_q[0];

endmodule
`default_nettype wire

// ===== sv/int128_alu_unit.sv =====
// Top level of the 128-bit integer ALU: controller, datapath and checks.
// Short operations go from setup straight to the result; mul, and div or mod with a nonzero
// divisor, also run the iterative loop, one bit a cycle, and a fix-up step before the result.
// One item is in work at a time: a new item is taken only once the result of the last one
// is loaded into the output register.
// Reset clears the controller and the output valid; operand registers are not reset.
`default_nettype none
module int128_alu_unit #(
  parameter int unsigned WORD_BITS = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  func_i,
  input  wire logic [1:0]  mode_i,
  input  wire logic [63:0] a_high_i,
  input  wire logic [63:0] a_low_i,
  input  wire logic [63:0] b_high_i,
  input  wire logic [63:0] b_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      r_high_o,
  output logic [63:0]      r_low_o,
  output logic             less_o,
  output logic             equal_o,
  output logic             greater_o,
  output logic             div_zero_o
);

  ialu_pkg::cmd_t    cmd;
  ialu_pkg::status_t status;
  logic [127:0] a_full, b_full, r_full;

  assign a_full = {a_high_i, a_low_i};
  assign b_full = {b_high_i, b_low_i};

  ialu_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ialu_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .func_i     (func_i),
    .mode_i     (mode_i),
    .a_i        (a_full[WORD_BITS-1:0]),
    .b_i        (b_full[WORD_BITS-1:0]),
    .r_o        (r_full),
    .less_o     (less_o),
    .equal_o    (equal_o),
    .greater_o  (greater_o),
    .div_zero_o (div_zero_o)
  );

  assign r_high_o = r_full[127:64];
  assign r_low_o  = r_full[63:0];

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({less_o, equal_o, greater_o}))
    else $error("more than one compare flag set");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_zero_o) |-> (r_high_o == 64'd0 && r_low_o == 64'd0 &&
                                     !less_o && !equal_o && !greater_o))
    else $error("division by zero gave a nonzero result");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

endmodule
`default_nettype wire

// ===== tb/sv/int128_alu_unit_tb.sv =====
// Self-checking testbench for the 128-bit integer ALU with random traffic and stalls.
`timescale 1ns / 100ps
`default_nettype none
module int128_alu_unit_tb;

  typedef struct packed {
    logic [63:0] r_high;
    logic [63:0] r_low;
    logic        less;
    logic        equal;
    logic        greater;
    logic        div_zero;
  } alu_result_t;

  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned HoldCycles = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [3:0]  func_i = '0;
  logic [1:0]  mode_i = '0;
  logic [63:0] a_high_i = '0;
  logic [63:0] a_low_i = '0;
  logic [63:0] b_high_i = '0;
  logic [63:0] b_low_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] r_high_o;
  logic [63:0] r_low_o;
  logic        less_o;
  logic        equal_o;
  logic        greater_o;
  logic        div_zero_o;

  alu_result_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  bit          recv_hold = 1'b0;

  int128_alu_unit u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Arithmetic on 128-bit words; signed variants go through magnitudes.
  function automatic logic [127:0] negate128(logic [127:0] x);
    return -x;
  endfunction

  function automatic alu_result_t compute_alu(logic [3:0] fn, logic [1:0] md,
                                              logic [127:0] a, logic [127:0] b);
    alu_result_t  res;
    logic         a_sgn, b_sgn, sa, sb, go_left;
    logic [127:0] ma, mb, quo, rem, cnt;
    res = '0;
    a_sgn = (md == ialu_pkg::MODE_SS) || (md == ialu_pkg::MODE_SU);
    b_sgn = (md == ialu_pkg::MODE_SS);
    sa = a_sgn & a[127];
    sb = b_sgn & b[127];
    case (fn)
      ialu_pkg::FN_ADD: {res.r_high, res.r_low} = a + b;
      ialu_pkg::FN_SUB: {res.r_high, res.r_low} = a - b;
      ialu_pkg::FN_MUL: {res.r_high, res.r_low} = a * b;
      ialu_pkg::FN_DIV, ialu_pkg::FN_MOD: begin
        if (b == '0) begin
          res.div_zero = 1'b1;
        end else begin
          ma = sa ? negate128(a) : a;
          mb = sb ? negate128(b) : b;
          quo = ma / mb;
          rem = ma % mb;
          if (fn == ialu_pkg::FN_DIV)
            {res.r_high, res.r_low} = (sa != sb) ? negate128(quo) : quo;
          else {res.r_high, res.r_low} = sa ? negate128(rem) : rem;
        end
      end
      ialu_pkg::FN_AND: {res.r_high, res.r_low} = a & b;
      ialu_pkg::FN_OR:  {res.r_high, res.r_low} = a | b;
      ialu_pkg::FN_XOR: {res.r_high, res.r_low} = a ^ b;
      ialu_pkg::FN_SHL, ialu_pkg::FN_SHR: begin
        go_left = (fn == ialu_pkg::FN_SHL);
        cnt = b;
        if (sb) begin
          cnt = negate128(b);
          go_left = ~go_left;
        end
        if (cnt >= 128) {res.r_high, res.r_low} = '0;
        else if (go_left) {res.r_high, res.r_low} = a << cnt[6:0];
        else if (a_sgn) {res.r_high, res.r_low} = $signed(a) >>> cnt[6:0];
        else {res.r_high, res.r_low} = a >> cnt[6:0];
      end
      ialu_pkg::FN_CMP: begin
        if (sa != sb) begin
          res.less = sa;
          res.greater = sb;
        end else if (a == b) res.equal = 1'b1;
        else if (a < b) res.less = 1'b1;
        else res.greater = 1'b1;
      end
      ialu_pkg::FN_NEG: {res.r_high, res.r_low} = negate128(a);
      default: ;
    endcase
    return res;
  endfunction

  // Valid stays up after a transfer so items can follow back to back;
  // it drops for an idle burst or when the sender pauses.
  task automatic send_item(logic [3:0] fn, logic [1:0] md,
                           logic [127:0] a, logic [127:0] b);
    int unsigned gap;
    if (send_gaps && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    mode_i <= md;
    {a_high_i, a_low_i} <= a;
    {b_high_i, b_low_i} <= b;
    expected_results.push_back(compute_alu(fn, md, a, b));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // The sender stops and waits until every expected result has come.
  task automatic pause_sender();
    in_valid_i <= 1'b0;
    wait (expected_results.size() == 0);
  endtask

  // Receiver side: random stall bursts, or a long hold when requested.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (recv_hold) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        recv_hold = 1'b0;
      end else if (recv_gaps && ($urandom_range(0, 4) == 0)) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 18);
        repeat (stall - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result check on each output transfer.
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (r_high_o !== want.r_high) begin
          $error("r_high expected %h actual %h", want.r_high, r_high_o);
          fail_count++;
        end
        if (r_low_o !== want.r_low) begin
          $error("r_low expected %h actual %h", want.r_low, r_low_o);
          fail_count++;
        end
        if (less_o !== want.less) begin
          $error("less expected %b actual %b", want.less, less_o);
          fail_count++;
        end
        if (equal_o !== want.equal) begin
          $error("equal expected %b actual %b", want.equal, equal_o);
          fail_count++;
        end
        if (greater_o !== want.greater) begin
          $error("greater expected %b actual %b", want.greater, greater_o);
          fail_count++;
        end
        if (div_zero_o !== want.div_zero) begin
          $error("div_zero expected %b actual %b", want.div_zero, div_zero_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Operands biased toward edge values and small numbers.
  function automatic logic [127:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {1'b1, 127'b0};
      3: return {1'b0, {127{1'b1}}};
      4: return 128'($urandom_range(0, 200));
      5: return negate128(128'($urandom_range(0, 200)));
      6: return rand128() >> $urandom_range(0, 127);
      default: return rand128();
    endcase
  endfunction

  task automatic test_directed();
    logic [127:0] min_s;
    min_s = {1'b1, 127'b0};
    send_item(ialu_pkg::FN_ADD, ialu_pkg::MODE_UU, '1, 128'd1);
    send_item(ialu_pkg::FN_SUB, ialu_pkg::MODE_UU, '0, 128'd1);
    send_item(ialu_pkg::FN_MUL, ialu_pkg::MODE_UU, '1, '1);
    send_item(ialu_pkg::FN_MUL, ialu_pkg::MODE_SS, min_s, 128'd3);
    send_item(ialu_pkg::FN_DIV, ialu_pkg::MODE_UU, 128'd100, '0);
    send_item(ialu_pkg::FN_MOD, ialu_pkg::MODE_SS, min_s, '0);
    send_item(ialu_pkg::FN_DIV, ialu_pkg::MODE_SS, min_s, '1);
    send_item(ialu_pkg::FN_DIV, ialu_pkg::MODE_SS, negate128(128'd7), 128'd2);
    send_item(ialu_pkg::FN_MOD, ialu_pkg::MODE_SS, negate128(128'd7), 128'd2);
    send_item(ialu_pkg::FN_MOD, ialu_pkg::MODE_SU, negate128(128'd7), '1);
    send_item(ialu_pkg::FN_AND, ialu_pkg::MODE_UU, '1, {2{64'h5555_aaaa_0f0f_f0f0}});
    send_item(ialu_pkg::FN_OR,  ialu_pkg::MODE_UU, '0, {2{64'hdead_beef_0123_4567}});
    send_item(ialu_pkg::FN_XOR, ialu_pkg::MODE_UU, '1, '1);
    send_item(ialu_pkg::FN_SHL, ialu_pkg::MODE_UU, '1, '0);
    send_item(ialu_pkg::FN_SHL, ialu_pkg::MODE_UU, '1, 128'd64);
    send_item(ialu_pkg::FN_SHL, ialu_pkg::MODE_UU, '1, 128'd128);
    send_item(ialu_pkg::FN_SHR, ialu_pkg::MODE_SU, min_s, 128'd127);
    send_item(ialu_pkg::FN_SHR, ialu_pkg::MODE_SS, min_s, negate128(128'd65));
    send_item(ialu_pkg::FN_SHL, ialu_pkg::MODE_SS, '1, min_s);
    send_item(ialu_pkg::FN_CMP, ialu_pkg::MODE_SS, min_s, 128'd1);
    send_item(ialu_pkg::FN_CMP, ialu_pkg::MODE_UU, min_s, 128'd1);
    send_item(ialu_pkg::FN_CMP, ialu_pkg::MODE_SU, '1, '1);
    send_item(ialu_pkg::FN_NEG, ialu_pkg::MODE_UU, min_s, '1);
    send_item(ialu_pkg::FN_ADD, 2'd3, '1, '1);
    send_item(4'd12, ialu_pkg::MODE_SS, '1, '1);
  endtask

  task automatic test_random(int unsigned count);
    logic [3:0]   fn;
    logic [127:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      b = pick_operand();
      if ((fn == ialu_pkg::FN_SHL || fn == ialu_pkg::FN_SHR) && $urandom_range(0, 2) != 0)
        b = ($urandom_range(0, 1) != 0) ? 128'($urandom_range(0, 130))
                                        : negate128(128'($urandom_range(0, 130)));
      send_item(fn, 2'($urandom_range(0, 3)), pick_operand(), b);
    end
  endtask

  // The receiver stops for a long stretch so the block backs up.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    test_random(6);
    pause_sender();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1400);
    test_backpressure();
    test_random(300);
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(200);
    pause_sender();
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
